@@ hw/rtl/ujse_pkg.sv @@
// ----------------------------------------------------------------------------
// ujse_pkg
// shared widths, job descriptor and character helpers for the json escaper
// ----------------------------------------------------------------------------
package ujse_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int CAP_BITS    = OFFSET_BITS + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CAP_BITS-1:0] CAP_MAX = CAP_BITS'(1) << OFFSET_BITS;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [2:0] {
        JOB_LIT,
        JOB_ESC2,
        JOB_U16,
        JOB_SURR,
        JOB_OVF
    } t_job_kind;

    typedef struct packed {
        t_job_kind              kind;
        logic [7:0]             ch;
        logic [15:0]            v0;
        logic [15:0]            v1;
        logic [OFFSET_BITS-1:0] pos;
    } t_job;

    function automatic logic [3:0] job_len(input t_job_kind kind);
        logic [3:0] len;
        unique case (kind)
            JOB_LIT:  len = 4'd1;
            JOB_ESC2: len = 4'd2;
            JOB_U16:  len = 4'd6;
            JOB_SURR: len = 4'd12;
            JOB_OVF:  len = 4'd1;
            default:  len = 4'd1;
        endcase
        return len;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'b0, nib};
        end else begin
            ch = 8'h57 + {4'b0, nib};
        end
        return ch;
    endfunction

endpackage

@@ hw/rtl/ujse_in_if.sv @@
// ----------------------------------------------------------------------------
// ujse_in_if
// source byte channel of the json escaper
// ----------------------------------------------------------------------------
interface ujse_in_if;
    import ujse_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [7:0]             data_byte;
    logic                   first_of_string;
    logic                   last_of_string;
    logic [OFFSET_BITS-1:0] start_offset;

    modport source (
        output valid, data_byte, first_of_string, last_of_string, start_offset,
        input  ready
    );
    modport sink (
        input  valid, data_byte, first_of_string, last_of_string, start_offset,
        output ready
    );
endinterface

@@ hw/rtl/ujse_out_if.sv @@
// ----------------------------------------------------------------------------
// ujse_out_if
// escaped character channel of the json escaper
// ----------------------------------------------------------------------------
interface ujse_out_if;
    import ujse_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [7:0]             out_byte;
    logic [OFFSET_BITS-1:0] out_position;
    logic                   overflow;
    logic                   last_of_run;

    modport source (
        output valid, out_byte, out_position, overflow, last_of_run,
        input  ready
    );
    modport sink (
        input  valid, out_byte, out_position, overflow, last_of_run,
        output ready
    );
endinterface

@@ hw/rtl/ujse_front.sv @@
// ----------------------------------------------------------------------------
// ujse_front
// utf-8 decode, escape classification and capacity check, one byte per cycle while the job queue has room
// ----------------------------------------------------------------------------
module ujse_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ujse_in_if.sink                  i_in,
    input  logic                     i_cfg_wr_en,
    input  logic [ujse_pkg::CAP_BITS-1:0] i_cfg_wr_data,
    input  logic                     i_q_full,
    output logic                     o_push,
    output ujse_pkg::t_job           o_job
);
    import ujse_pkg::*;

    logic [CAP_BITS-1:0] r_cap;
    logic [20:0]         r_cp, n_cp;
    logic [1:0]          r_br, n_br;
    logic [CAP_BITS-1:0] r_wo, n_wo;
    logic                r_failed, n_failed;

    logic [20:0]         cp_e;
    logic [1:0]          br_e;
    logic [CAP_BITS-1:0] wo_e;
    logic                failed_e;
    logic [7:0]          c;
    logic [20:0]         cp_sh;
    logic [20:0]         d;
    logic [CAP_BITS-1:0] cap_c;
    logic [CAP_BITS-1:0] need;
    logic [3:0]          len;
    logic                has;
    logic                accept;

    assign c        = i_in.data_byte;
    assign cp_e     = i_in.first_of_string ? '0 : r_cp;
    assign br_e     = i_in.first_of_string ? '0 : r_br;
    assign wo_e     = i_in.first_of_string ? CAP_BITS'(i_in.start_offset) : r_wo;
    assign failed_e = i_in.first_of_string ? 1'b0 : r_failed;
    assign cp_sh    = {cp_e[14:0], c[5:0]};
    assign d        = cp_sh - 21'h010000;
    assign cap_c    = (r_cap > CAP_MAX) ? CAP_MAX : r_cap;

    assign i_in.ready = !i_q_full;
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = accept && has;

    always_comb begin
        n_cp       = cp_e;
        n_br       = br_e;
        n_wo       = wo_e;
        n_failed   = failed_e;
        has        = 1'b0;
        len        = 4'd1;
        need       = '0;
        o_job.kind = JOB_LIT;
        o_job.ch   = '0;
        o_job.v0   = '0;
        o_job.v1   = '0;
        o_job.pos  = wo_e[OFFSET_BITS-1:0];
        if (!failed_e) begin
            if (c != 8'h00) begin
                if (br_e != 2'd0) begin
                    if (c[7:6] == 2'b10) begin
                        n_cp = cp_sh;
                        n_br = br_e - 2'd1;
                        if (br_e == 2'd1) begin
                            has = 1'b1;
                            if (cp_sh > 21'h00FFFF) begin
                                o_job.kind = JOB_SURR;
                                o_job.v0   = 16'hD800 + {5'b0, d[20:10]};
                                o_job.v1   = 16'hDC00 | {6'b0, d[9:0]};
                            end else begin
                                o_job.kind = JOB_U16;
                                o_job.v0   = cp_sh[15:0];
                            end
                        end
                    end else begin
                        has      = 1'b1;
                        o_job.ch = CH_QMARK;
                        n_br     = '0;
                        n_cp     = '0;
                    end
                end else begin
                    has = 1'b1;
                    priority if (c == CH_QUOTE || c == CH_BSLASH) begin
                        o_job.kind = JOB_ESC2;
                        o_job.ch   = c;
                    end else if (c == CH_LF) begin
                        o_job.kind = JOB_ESC2;
                        o_job.ch   = CH_N;
                    end else if (c == CH_CR) begin
                        o_job.kind = JOB_ESC2;
                        o_job.ch   = CH_R;
                    end else if (c == CH_TAB) begin
                        o_job.kind = JOB_ESC2;
                        o_job.ch   = CH_T;
                    end else if (c < CH_SPACE) begin
                        o_job.kind = JOB_U16;
                        o_job.v0   = {8'b0, c};
                    end else if (c[7]) begin
                        priority if (c[7:5] == 3'b110) begin
                            has  = 1'b0;
                            n_cp = {16'b0, c[4:0]};
                            n_br = 2'd1;
                        end else if (c[7:4] == 4'b1110) begin
                            has  = 1'b0;
                            n_cp = {17'b0, c[3:0]};
                            n_br = 2'd2;
                        end else if (c[7:3] == 5'b11110) begin
                            has  = 1'b0;
                            n_cp = {18'b0, c[2:0]};
                            n_br = 2'd3;
                        end else begin
                            o_job.ch = CH_QMARK;
                        end
                    end else begin
                        o_job.ch = c;
                    end
                end
            end
            // cut-off sequence at string end
            if (i_in.last_of_string && n_br != 2'd0) begin
                has        = 1'b1;
                o_job.kind = JOB_LIT;
                o_job.ch   = CH_QMARK;
                n_br       = '0;
                n_cp       = '0;
            end
            if (has) begin
                len  = job_len(o_job.kind);
                need = wo_e + CAP_BITS'(len) + CAP_BITS'(1);
                if (need > cap_c) begin
                    o_job.kind = JOB_OVF;
                    n_failed   = 1'b1;
                end else begin
                    n_wo = wo_e + CAP_BITS'(len);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap    <= CAP_MAX;
            r_cp     <= '0;
            r_br     <= '0;
            r_wo     <= '0;
            r_failed <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (accept) begin
                r_cp     <= n_cp;
                r_br     <= n_br;
                r_wo     <= n_wo;
                r_failed <= n_failed;
            end
        end
    end

endmodule

@@ hw/rtl/ujse_queue.sv @@
// ----------------------------------------------------------------------------
// ujse_queue
// small job queue between the classifier and the expander
// ----------------------------------------------------------------------------
module ujse_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ujse_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_head_valid,
    output ujse_pkg::t_job o_head
);
    import ujse_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QPTR_W:0]   r_cnt;

    assign o_full       = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ hw/rtl/ujse_back.sv @@
// ----------------------------------------------------------------------------
// ujse_back
// expands queued jobs into escaped characters, one beat per cycle while the output is ready
// ----------------------------------------------------------------------------
module ujse_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_head_valid,
    input  ujse_pkg::t_job i_head,
    output logic           o_pop,
    ujse_out_if.source     o_out
);
    import ujse_pkg::*;

    logic [3:0]             r_k;
    logic                   r_valid;
    logic [7:0]             r_byte;
    logic [OFFSET_BITS-1:0] r_pos;
    logic                   r_ovf;
    logic                   r_last;

    logic                   load;
    logic                   at_end;
    logic [3:0]             len;
    logic                   upper;
    logic [3:0]             sub;
    logic [15:0]            v;
    logic [7:0]             n_byte;

    assign len    = job_len(i_head.kind);
    assign load   = i_head_valid && (!r_valid || o_out.ready);
    assign at_end = (r_k == len - 4'd1);
    assign o_pop  = load && at_end;
    assign upper  = (r_k >= 4'd6);
    assign sub    = upper ? (r_k - 4'd6) : r_k;
    assign v      = upper ? i_head.v1 : i_head.v0;

    always_comb begin
        unique case (i_head.kind)
            JOB_LIT:  n_byte = i_head.ch;
            JOB_ESC2: n_byte = (r_k == 4'd0) ? CH_BSLASH : i_head.ch;
            JOB_U16, JOB_SURR: begin
                unique case (sub)
                    4'd0:    n_byte = CH_BSLASH;
                    4'd1:    n_byte = CH_U;
                    4'd2:    n_byte = hex_char(v[15:12]);
                    4'd3:    n_byte = hex_char(v[11:8]);
                    4'd4:    n_byte = hex_char(v[7:4]);
                    default: n_byte = hex_char(v[3:0]);
                endcase
            end
            JOB_OVF:  n_byte = 8'h00;
            default:  n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= n_byte;
            r_pos  <= i_head.pos + OFFSET_BITS'(r_k);
            r_ovf  <= (i_head.kind == JOB_OVF);
            r_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k     <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_k     <= at_end ? 4'd0 : r_k + 4'd1;
                r_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid        = r_valid;
    assign o_out.out_byte     = r_byte;
    assign o_out.out_position = r_pos;
    assign o_out.overflow     = r_ovf;
    assign o_out.last_of_run  = r_last;

endmodule

@@ hw/rtl/utf8_json_string_escaper.sv @@
// ----------------------------------------------------------------------------
// utf8_json_string_escaper
// utf-8 bytes in, json-escaped characters with destination offsets out
// ----------------------------------------------------------------------------
//  port        dir  kind          beat carries
//  i_in        in   valid/ready   data_byte, first/last_of_string, start_offset
//  o_out       out  valid/ready   out_byte, out_position, overflow, last_of_run
//  i_cfg_wr_*  in   write enable  buffer_capacity
//
//  one source byte accepted per cycle while the 4-entry job queue has room
//  output beats per byte: 0, 1 (plain, '?' or overflow), 2, 6 or 12; one per cycle while o_out is ready
//  the single output register drains jobs, so long escapes backpressure input
//  an accepted byte's job is written into the queue, then loaded into the output register
//  synchronous reset clears state and sets capacity to 65536
// ----------------------------------------------------------------------------
module utf8_json_string_escaper (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ujse_in_if.sink                       i_in,
    ujse_out_if.source                    o_out,
    input  logic                          i_cfg_wr_en,
    input  logic [ujse_pkg::CAP_BITS-1:0] i_cfg_wr_data
);
    import ujse_pkg::*;

    logic q_full;
    logic push;
    logic pop;
    logic head_valid;
    t_job job;
    t_job head;

    ujse_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (i_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (job)
    );

    ujse_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    ujse_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

@@ hw/rtl/ujse_checker.sv @@
// ----------------------------------------------------------------------------
// ujse_checker
// port-level checks on the escaper output channel
// ----------------------------------------------------------------------------
module ujse_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_out_valid,
    input logic                             i_out_ready,
    input logic [7:0]                       i_out_byte,
    input logic [ujse_pkg::OFFSET_BITS-1:0] i_out_position,
    input logic                             i_out_overflow,
    input logic                             i_out_last
);
    import ujse_pkg::*;

    logic                   r_open;
    logic [OFFSET_BITS-1:0] r_next_pos;
    logic                   beat;

    assign beat = i_out_valid && i_out_ready;

    // track the run in progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open     <= 1'b0;
            r_next_pos <= '0;
        end else if (beat) begin
            r_open     <= !i_out_last;
            r_next_pos <= i_out_position + OFFSET_BITS'(1);
        end
    end

    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
            && $stable(i_out_position) && $stable(i_out_last))
        else $error("stalled beat changed");

    a_overflow_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_overflow |-> i_out_last && i_out_byte == 8'h00)
        else $error("overflow beat not a lone zero beat");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        beat && r_open |-> i_out_position == r_next_pos && !i_out_overflow)
        else $error("beats of one run not at consecutive offsets");

endmodule

bind utf8_json_string_escaper ujse_checker u_ujse_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_byte     (o_out.out_byte),
    .i_out_position (o_out.out_position),
    .i_out_overflow (o_out.overflow),
    .i_out_last     (o_out.last_of_run)
);

@@ sim/utf8_json_string_escaper_tb.sv @@
// ----------------------------------------------------------------------------
// utf8_json_string_escaper_tb
// drives utf-8 strings into the escaper and checks every escaped beat,
// position, overflow flag and run marker against a local escape predictor,
// under several capacities and with random idle and stall on both channels
// ----------------------------------------------------------------------------
module utf8_json_string_escaper_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ujse_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic [7:0]             ch;
        logic [OFFSET_BITS-1:0] pos;
        logic                   ovf;
        logic                   last;
    } t_char_beat;

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [CAP_BITS-1:0] i_cfg_wr_data = '0;

    ujse_in_if  in_if ();
    ujse_out_if out_if ();

    utf8_json_string_escaper uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in          (in_if),
        .o_out         (out_if),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // predictor state
    logic [CAP_BITS-1:0] cap_reg;
    logic [20:0]         cp_acc;
    logic [1:0]          cont_left;
    int                  wr_off;
    bit                  str_failed;

    t_char_beat  pending_chars[$];
    logic [7:0]  esc_chars[$];
    logic [7:0]  str_bytes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int live_bytes     = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    always begin
        #2 i_clk = ~i_clk;
    end

    function logic [7:0] nibble_char(input logic [3:0] nib);
        return (nib > 4'd9) ? 8'h61 + 8'(nib - 4'd10) : 8'h30 + 8'(nib);
    endfunction

    function void push_u_escape(input logic [15:0] v);
        esc_chars.push_back(CH_BSLASH);
        esc_chars.push_back(CH_U);
        esc_chars.push_back(nibble_char(v[15:12]));
        esc_chars.push_back(nibble_char(v[11:8]));
        esc_chars.push_back(nibble_char(v[7:4]));
        esc_chars.push_back(nibble_char(v[3:0]));
    endfunction

    function void push_code_point(input logic [20:0] cp);
        logic [20:0] d;
        if (cp > 21'h00FFFF) begin
            d = cp - 21'h010000;
            push_u_escape(16'hD800 + 16'(d[20:10]));
            push_u_escape(16'hDC00 + 16'(d[9:0]));
        end else begin
            push_u_escape(cp[15:0]);
        end
    endfunction

    function void push_pair(input logic [7:0] ch);
        esc_chars.push_back(CH_BSLASH);
        esc_chars.push_back(ch);
    endfunction

    function void escape_model_byte(input logic [7:0] b, input logic first,
                                    input logic last, input logic [15:0] start);
        int cap_eff;
        int n;
        esc_chars.delete();
        live_bytes++;
        if (first) begin
            wr_off     = start;
            cp_acc     = '0;
            cont_left  = '0;
            str_failed = 1'b0;
        end
        if (str_failed) return;

        if (b != 8'h00) begin
            if (cont_left != 2'd0) begin
                if (b[7:6] == 2'b10) begin
                    cp_acc = {cp_acc[14:0], b[5:0]};
                    cont_left--;
                    if (cont_left == 2'd0) push_code_point(cp_acc);
                end else begin
                    esc_chars.push_back(CH_QMARK);
                    cont_left = '0;
                    cp_acc    = '0;
                end
            end else if (b == CH_QUOTE || b == CH_BSLASH) begin
                push_pair(b);
            end else if (b == CH_LF) begin
                push_pair(CH_N);
            end else if (b == CH_CR) begin
                push_pair(CH_R);
            end else if (b == CH_TAB) begin
                push_pair(CH_T);
            end else if (b < CH_SPACE) begin
                push_u_escape({8'h00, b});
            end else if (b[7]) begin
                if (b[7:5] == 3'b110) begin
                    cp_acc = 21'(b[4:0]);
                    cont_left = 2'd1;
                end else if (b[7:4] == 4'b1110) begin
                    cp_acc = 21'(b[3:0]);
                    cont_left = 2'd2;
                end else if (b[7:3] == 5'b11110) begin
                    cp_acc = 21'(b[2:0]);
                    cont_left = 2'd3;
                end else begin
                    esc_chars.push_back(CH_QMARK);
                end
            end else begin
                esc_chars.push_back(b);
            end
        end

        // sequence cut off at end of string
        if (last && cont_left != 2'd0) begin
            esc_chars.delete();
            esc_chars.push_back(CH_QMARK);
            cont_left = '0;
            cp_acc    = '0;
        end

        n = esc_chars.size();
        if (n == 0) return;
        cap_eff = (cap_reg > CAP_MAX) ? int'(CAP_MAX) : int'(cap_reg);
        if (wr_off + n + 1 > cap_eff) begin
            pending_chars.push_back({8'h00, 16'(wr_off), 1'b1, 1'b1});
            str_failed = 1'b1;
        end else begin
            for (int i = 0; i < n; i++) begin
                pending_chars.push_back({esc_chars[i], 16'(wr_off + i), 1'b0, i == n - 1});
            end
            wr_off += n;
        end
    endfunction

    // receiver: random stall, or a counted hold-off when requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_if.ready <= 1'b0;
            hold_left--;
        end else begin
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : check_beats
        t_char_beat got;
        t_char_beat want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = {out_if.out_byte, out_if.out_position, out_if.overflow, out_if.last_of_run};
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected beat ch=%h pos=%h ovf=%b last=%b", $time,
                         got.ch, got.pos, got.ovf, got.last);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (got.ch !== want.ch || got.pos !== want.pos ||
                    got.ovf !== want.ovf || got.last !== want.last) begin
                    $display("%0t: beat mismatch exp ch=%h pos=%h ovf=%b last=%b got ch=%h pos=%h ovf=%b last=%b",
                             $time, want.ch, want.pos, want.ovf, want.last,
                             got.ch, got.pos, got.ovf, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("utf8_json_string_escaper_tb: errors");
        $finish;
    end

    task automatic send_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [15:0] start);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid           <= 1'b1;
        in_if.data_byte       <= b;
        in_if.first_of_string <= first;
        in_if.last_of_string  <= last;
        in_if.start_offset    <= start;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        escape_model_byte(b, first, last, start);
    endtask

    task automatic send_string(input logic [15:0] start);
        int n;
        n = str_bytes.size();
        for (int i = 0; i < n; i++) begin
            send_byte(str_bytes[i], i == 0, i == n - 1, start);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] v);
        settle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cap_reg = v;
    endtask

    task automatic push_sequence(input int n_cont, input int keep);
        case (n_cont)
            1: str_bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            2: str_bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            default: str_bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
        endcase
        for (int k = 0; k < keep; k++) begin
            str_bytes.push_back(8'h80 | 8'($urandom_range(0, 63)));
        end
    endtask

    task automatic build_random_string();
        int n_chars;
        int r;
        int n_cont;
        str_bytes.delete();
        n_chars = $urandom_range(1, 10);
        for (int c = 0; c < n_chars; c++) begin
            r = $urandom_range(0, 99);
            if (r < 30) begin
                str_bytes.push_back(8'($urandom_range(32, 127)));
            end else if (r < 40) begin
                case ($urandom_range(0, 4))
                    0: str_bytes.push_back(CH_QUOTE);
                    1: str_bytes.push_back(CH_BSLASH);
                    2: str_bytes.push_back(CH_LF);
                    3: str_bytes.push_back(CH_CR);
                    default: str_bytes.push_back(CH_TAB);
                endcase
            end else if (r < 48) begin
                str_bytes.push_back(8'($urandom_range(1, 31)));
            end else if (r < 80) begin
                n_cont = $urandom_range(1, 3);
                push_sequence(n_cont, n_cont);
            end else if (r < 88) begin
                // truncated sequence
                n_cont = $urandom_range(1, 3);
                push_sequence(n_cont, $urandom_range(0, n_cont - 1));
            end else begin
                str_bytes.push_back(8'($urandom_range(1, 255)));
            end
        end
    endtask

    function automatic logic [15:0] pick_start(input logic [CAP_BITS-1:0] cap);
        int lim;
        int s;
        int r;
        lim = (cap > CAP_MAX) ? int'(CAP_MAX) : int'(cap);
        r = $urandom_range(0, 99);
        if (r < 60) begin
            s = $urandom_range(0, 80);
        end else if (r < 80) begin
            s = lim - int'($urandom_range(1, 40));
        end else begin
            s = $urandom_range(0, 65535);
        end
        if (s < 0) s = 0;
        if (s > 65535) s = 65535;
        return 16'(s);
    endfunction

    task automatic test_escapes();
        str_bytes = '{CH_QUOTE, CH_BSLASH, CH_LF, CH_CR, CH_TAB, 8'h01, 8'h1F, 8'h7E};
        send_string(16'h1000);
    endtask

    task automatic test_multibyte();
        // two-byte, three-byte, surrogate pair, bad leads, bad continuation,
        // zero byte inside a pending sequence
        str_bytes = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                      8'hF8, 8'h80, 8'hC3, 8'h41, 8'hC3, 8'h00, 8'hA9};
        send_string(16'h0000);
        // cut off at end of string
        str_bytes = '{8'hE2, 8'h82};
        send_string(16'h0040);
    endtask

    task automatic test_capacity();
        write_capacity(17'd1);
        str_bytes = '{8'h41, 8'h42};
        send_string(16'h0000);
        write_capacity(17'd0);
        str_bytes = '{8'h41};
        send_string(16'h0000);
        write_capacity(17'h1FFFF);
        str_bytes = '{8'h41, 8'h42};
        send_string(16'hFFFE);
        write_capacity(CAP_MAX);
        str_bytes = '{CH_LF};
        send_string(16'hFFFF);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [CAP_BITS-1:0] cap, input int n_bytes);
        int target;
        write_capacity(cap);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = live_bytes + n_bytes;
        while (live_bytes < target) begin
            build_random_string();
            send_string(pick_start(cap));
        end
    endtask

    task automatic test_backpressure();
        write_capacity(CAP_MAX);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        str_bytes.delete();
        for (int i = 0; i < 24; i++) begin
            str_bytes.push_back(8'($urandom_range(1, 8)));
        end
        @(posedge i_clk);
        hold_left = 150;
        send_string(16'h0100);
    endtask

    initial begin
        in_if.valid           = 1'b0;
        in_if.data_byte       = 8'h00;
        in_if.first_of_string = 1'b0;
        in_if.last_of_string  = 1'b0;
        in_if.start_offset    = '0;
        out_if.ready          = 1'b0;
        cap_reg    = CAP_MAX;
        cp_acc     = '0;
        cont_left  = '0;
        wr_off     = 0;
        str_failed = 1'b0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_escapes();
        test_multibyte();
        test_capacity();
        test_random_traffic(0, 0, CAP_MAX, 60);
        test_random_traffic(88, 0, 17'd100, 60);
        test_random_traffic(0, 88, 17'd40, 60);
        test_random_traffic(33, 33, CAP_BITS'($urandom_range(1, 65536)), 60);
        test_backpressure();
        settle();

        if (mismatch_count == 0) begin
            $display("utf8_json_string_escaper_tb: clean");
        end else begin
            $display("utf8_json_string_escaper_tb: errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/ujse_pkg.sv
hw/rtl/ujse_in_if.sv
hw/rtl/ujse_out_if.sv
hw/rtl/ujse_front.sv
hw/rtl/ujse_queue.sv
hw/rtl/ujse_back.sv
hw/rtl/utf8_json_string_escaper.sv
hw/rtl/ujse_checker.sv
sim/utf8_json_string_escaper_tb.sv
